@@ src/branch_trace_tnt_bit_fifo_core_defines.svh @@
// Assertion macros for the branch trace TNT bit FIFO.
// Used by the checker; depends on clk and arst_n in the including scope.
`ifndef BRANCH_TRACE_TNT_BIT_FIFO_CORE_DEFINES_SVH
`define BRANCH_TRACE_TNT_BIT_FIFO_CORE_DEFINES_SVH

// check outside reset
`define BTBF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check that holds once reset is released, past cycle included
`define BTBF_ASSERT_PAST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n || !$past(arst_n)) prop) \
		else $error(msg);

`endif

@@ src/btbf_pkg.sv @@
// Shared types and constants of the branch trace TNT bit FIFO.
// No dependencies.
package btbf_pkg;

	localparam int DEPTH  = 4096;
	localparam int PTR_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int PEND_W = 13;
	localparam int PKT_W  = 64;
	localparam int POS_W  = 6;
	localparam int SHORT_W = 8;

	localparam logic [POS_W-1:0] SHORT_OFFSET = POS_W'(1);
	localparam logic [POS_W-1:0] LONG_OFFSET  = POS_W'(16);
	localparam logic [1:0]       EMPTY_CODE   = 2'd2;

	typedef enum logic [1:0] {
		CMD_SHORT = 2'd0,
		CMD_LONG  = 2'd1,
		CMD_POP   = 2'd2,
		CMD_FLUSH = 2'd3
	} cmd_t;

	typedef struct packed {
		logic load;
		logic is_long;
		logic shift;
	} shift_ctl_t;

	typedef struct packed {
		logic             head;
		logic [POS_W-1:0] pos;
	} shift_stat_t;

endpackage

@@ src/btbf_shift.sv @@
// Packet shift register: scans for the stop bit and feeds payload bits, MSB first.
// Depends on btbf_pkg.
module btbf_shift (
	input  logic                            clk,
	input  logic [btbf_pkg::PKT_W-1:0]      packet,
	input  btbf_pkg::shift_ctl_t            ctl,
	output btbf_pkg::shift_stat_t           stat
);

	logic [btbf_pkg::PKT_W-1:0] sh_q;
	logic [btbf_pkg::POS_W-1:0] pos_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			if (ctl.is_long) begin
				sh_q  <= packet;
				pos_q <= btbf_pkg::POS_W'(btbf_pkg::PKT_W - 1);
			end else begin
				sh_q  <= {packet[btbf_pkg::SHORT_W-1:0],
					{(btbf_pkg::PKT_W - btbf_pkg::SHORT_W){1'b0}}};
				pos_q <= btbf_pkg::POS_W'(btbf_pkg::SHORT_W - 1);
			end
		end else if (ctl.shift) begin
			sh_q  <= {sh_q[btbf_pkg::PKT_W-2:0], 1'b0};
			pos_q <= pos_q - 1'b1;
		end
	end

	assign stat.head = sh_q[btbf_pkg::PKT_W-1];
	assign stat.pos  = pos_q;

endmodule

@@ src/btbf_mem.sv @@
// Single-bit ring store, one write and one registered read port.
// Depends on btbf_pkg.
module btbf_mem (
	input  logic                       clk,
	input  logic                       we,
	input  logic [btbf_pkg::PTR_W-1:0] waddr,
	input  logic                       wdata,
	input  logic [btbf_pkg::PTR_W-1:0] raddr,
	output logic                       rdata
);

	logic mem [btbf_pkg::DEPTH];
	logic rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ src/branch_trace_tnt_bit_fifo_core.sv @@
// Top level of the branch trace TNT bit FIFO: command sequencer and output register.
// Depends on btbf_pkg, btbf_shift and btbf_mem.
//
//   port group  dir  fields (low bit up)
//   s_*         in   tuser: cmd[1:0]; tdata: packet[63:0]
//   m_*         out  tdata: branch_bit[1:0], pending[14:2], overflow[15]
//
// Short and long appends move one bit per cycle through the packet shift register,
// scanning for the stop bit and then writing the payload bits into the store.
// Pop reads the store through its registered read port; flush and empty pop go
// straight to the result.
// s_tready is high only between items; a held result does not block the next item
// until the next result is due. Reset clears pointers and count, no clearing pass.
module branch_trace_tnt_bit_fifo_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // packet[63:0]
	input  logic [1:0]  s_tuser,  // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // branch_bit[1:0], pending[14:2], overflow[15]
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_POP_RD,
		ST_POP_DATA,
		ST_DONE
	} state_t;

	state_t                        state_q;
	logic [btbf_pkg::PTR_W-1:0]    rptr_q;
	logic [btbf_pkg::PTR_W-1:0]    wptr_q;
	logic [btbf_pkg::CNT_W-1:0]    fill_q;
	logic [btbf_pkg::POS_W-1:0]    remain_q;
	logic                          long_q;
	logic [1:0]                    bit_q;
	logic                          ovf_q;
	logic                          out_valid_q;
	logic [15:0]                   out_data_q;

	btbf_pkg::shift_ctl_t          sctl;
	btbf_pkg::shift_stat_t         sstat;
	logic                          rdata;
	logic [btbf_pkg::POS_W-1:0]    offset;
	logic [btbf_pkg::POS_W-1:0]    cnt;
	logic                          no_room;
	logic                          accept;
	btbf_pkg::cmd_t                cmd;

	assign cmd     = btbf_pkg::cmd_t'(s_tuser);
	assign accept  = s_tvalid && s_tready;
	assign offset  = long_q ? btbf_pkg::LONG_OFFSET : btbf_pkg::SHORT_OFFSET;
	assign cnt     = sstat.pos - offset;
	assign no_room = ({1'b0, fill_q} + (btbf_pkg::CNT_W + 1)'(cnt))
		> (btbf_pkg::CNT_W + 1)'(btbf_pkg::DEPTH);

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		sctl.load    = accept && (cmd == btbf_pkg::CMD_SHORT || cmd == btbf_pkg::CMD_LONG);
		sctl.is_long = (cmd == btbf_pkg::CMD_LONG);
		sctl.shift   = (state_q == ST_WRITE) ||
			(state_q == ST_SCAN && sstat.pos > offset);
	end

	btbf_shift u_shift (
		.clk    (clk),
		.packet (s_tdata),
		.ctl    (sctl),
		.stat   (sstat)
	);

	btbf_mem u_mem (
		.clk   (clk),
		.we    (state_q == ST_WRITE),
		.waddr (wptr_q),
		.wdata (sstat.head),
		.raddr (rptr_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rptr_q      <= '0;
			wptr_q      <= '0;
			fill_q      <= '0;
			remain_q    <= '0;
			long_q      <= 1'b0;
			bit_q       <= btbf_pkg::EMPTY_CODE;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (m_tvalid && m_tready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						bit_q  <= btbf_pkg::EMPTY_CODE;
						ovf_q  <= 1'b0;
						long_q <= (cmd == btbf_pkg::CMD_LONG);
						unique case (cmd)
							btbf_pkg::CMD_SHORT, btbf_pkg::CMD_LONG: begin
								state_q <= ST_SCAN;
							end
							btbf_pkg::CMD_POP: begin
								state_q <= (fill_q == '0) ? ST_DONE : ST_POP_RD;
							end
							btbf_pkg::CMD_FLUSH: begin
								rptr_q  <= '0;
								wptr_q  <= '0;
								fill_q  <= '0;
								state_q <= ST_DONE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (sstat.pos <= offset) begin
						state_q <= ST_DONE;
					end else if (sstat.head) begin
						if (no_room) begin
							ovf_q   <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							remain_q <= cnt;
							state_q  <= ST_WRITE;
						end
					end
				end
				ST_WRITE: begin
					wptr_q   <= (wptr_q == btbf_pkg::PTR_W'(btbf_pkg::DEPTH - 1)) ?
						'0 : wptr_q + 1'b1;
					fill_q   <= fill_q + 1'b1;
					remain_q <= remain_q - 1'b1;
					if (remain_q == btbf_pkg::POS_W'(1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_POP_RD: begin
					state_q <= ST_POP_DATA;
				end
				ST_POP_DATA: begin
					bit_q   <= {1'b0, rdata};
					rptr_q  <= (rptr_q == btbf_pkg::PTR_W'(btbf_pkg::DEPTH - 1)) ?
						'0 : rptr_q + 1'b1;
					fill_q  <= fill_q - 1'b1;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {ovf_q, btbf_pkg::PEND_W'(fill_q), bit_q};
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

@@ src/btbf_checker.sv @@
// Port-level checker for the branch trace TNT bit FIFO, bound to the top level.
// Depends on btbf_pkg and branch_trace_tnt_bit_fifo_core_defines.svh.
`include "branch_trace_tnt_bit_fifo_core_defines.svh"

module btbf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	`BTBF_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result item dropped while stalled")
	`BTBF_ASSERT(a_bit_code, m_tvalid |-> m_tdata[1:0] != 2'd3, "invalid branch bit code")
	`BTBF_ASSERT(a_pend_max, m_tvalid |-> m_tdata[14:2] <= btbf_pkg::PEND_W'(btbf_pkg::DEPTH), "pending exceeds depth")
	`BTBF_ASSERT_PAST(a_ovf_empty, m_tvalid && m_tdata[15] |-> m_tdata[1:0] == btbf_pkg::EMPTY_CODE, "overflow with popped bit")

endmodule

bind branch_trace_tnt_bit_fifo_core btbf_checker u_btbf_checker (.*);
